[design/pcfp_pkg.sv]
`default_nettype none
package pcfp_pkg;

    localparam int FRAC = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 47;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_WEIGHT   = 3'd3,
        REG_ALPHA    = 3'd4,
        REG_OUT_LO   = 3'd5,
        REG_OUT_HI   = 3'd6,
        REG_INT_LIM  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic signed [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               busy;
        logic signed [63:0] quotient;
    } div_rsp_t;

    function automatic logic signed [63:0] clamp_int(
        input logic signed [63:0] v,
        input logic [46:0]        lim
    );
        logic signed [63:0] hi;
        logic signed [63:0] res;
        hi  = $signed({17'd0, lim});
        res = v;
        if (res > hi)
        begin
            res = hi;
        end
        if (res < -hi)
        begin
            res = -hi;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[design/pcfp_div.sv]
`default_nettype none
module pcfp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcfp_pkg::div_req_t req,
    output pcfp_pkg::div_rsp_t     rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] dsr_reg;

    logic [32:0] shifted;
    logic        fits;

    assign shifted = {rem_reg[31:0], quo_reg[63]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                neg_reg  <= req.dividend[63] ^ req.divisor[31];
                quo_reg  <= req.dividend[63] ? 64'(-req.dividend) : req.dividend;
                dsr_reg  <= req.divisor[31] ? 32'(-req.divisor) : req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (shifted - {1'b0, dsr_reg}) : shifted;
                quo_reg <= {quo_reg[62:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule
`default_nettype wire

[design/pid_controller_fixed_point.sv]
// A time step of zero or less gives a result of zero. A compute item forms
// the weighted error and the proportional and integral terms, then, once
// primed, the derivative division and filter, the clamped sum and, when it runs,
// back-calculation. Throughput: one item at a time; the next item is taken once
// any pending result transaction has completed. Reset is asynchronous, active
// low, restores register defaults and clears the state.
`default_nettype none
module pid_controller_fixed_point (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               operation,
    input  wire logic signed [31:0]                 target,
    input  wire logic signed [31:0]                 measured,
    input  wire logic signed [31:0]                 time_step,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [31:0]                      drive,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pcfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pcfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_WT, S_PROP, S_INC, S_IL, S_IH, S_DSTART, S_DWAIT,
        S_F1, S_F2, S_FD, S_SUM, S_BSTART, S_BWAIT, S_FIN
    } state_t;

    state_t state_reg;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg, out_lo_reg, out_hi_reg;
    logic [16:0]        weight_reg, alpha_reg;
    logic [46:0]        lim_reg;

    logic signed [63:0] acc_reg;
    logic signed [31:0] last_reg;
    logic               primed_reg;
    logic signed [31:0] df_reg;

    logic signed [31:0] tgt_reg, meas_reg, dt_reg;
    logic signed [31:0] wt_reg, prop_reg, iterm_reg, sample_reg, t1_reg, deriv_reg;
    logic signed [31:0] back_reg, drive_reg;
    logic [47:0]        p1_reg;
    logic               out_valid_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [31:0] fm;
    logic signed [63:0] inc;
    logic signed [31:0] total;
    logic signed [31:0] drv;
    logic [47:0]        isum;
    logic signed [31:0] wt_diff;
    logic signed [31:0] err;

    pcfp_pkg::div_req_t dreq;
    pcfp_pkg::div_rsp_t drsp;

    pcfp_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    assign wt_diff = wt_reg - meas_reg;
    assign err     = tgt_reg - meas_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_WT:
            begin
                mul_a = $signed({16'd0, weight_reg});
                mul_b = 33'(tgt_reg);
            end
            S_PROP:
            begin
                mul_a = 33'(gain_p_reg);
                mul_b = 33'(wt_diff);
            end
            S_INC:
            begin
                mul_a = 33'(err);
                mul_b = 33'(dt_reg);
            end
            S_IL:
            begin
                mul_a = $signed({9'd0, acc_reg[23:0]});
                mul_b = 33'(gain_i_reg);
            end
            S_IH:
            begin
                mul_a = 33'($signed(acc_reg[47:24]));
                mul_b = 33'(gain_i_reg);
            end
            S_F1:
            begin
                mul_a = 33'(df_reg);
                mul_b = $signed({16'd0, alpha_reg});
            end
            S_F2:
            begin
                mul_a = 33'(sample_reg);
                mul_b = 33'sd65536 - $signed({16'd0, alpha_reg});
            end
            S_FD:
            begin
                mul_a = 33'(gain_d_reg);
                mul_b = 33'(df_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign fm    = prod[pcfp_pkg::FRAC+31:pcfp_pkg::FRAC];
    assign inc   = 64'(prod >>> pcfp_pkg::FRAC);
    assign isum  = p1_reg + {prod[23:0], 24'd0};
    assign total = prop_reg + iterm_reg + deriv_reg;

    always_comb
    begin
        if (total < out_lo_reg)
        begin
            drv = out_lo_reg;
        end
        else if (total > out_hi_reg)
        begin
            drv = out_hi_reg;
        end
        else
        begin
            drv = total;
        end
    end

    always_comb
    begin
        dreq.start    = (state_reg == S_DSTART) || (state_reg == S_BSTART);
        dreq.divisor  = (state_reg == S_BSTART) ? gain_i_reg : dt_reg;
        dreq.dividend = (state_reg == S_BSTART) ? 64'($signed({back_reg, 16'd0}))
                                                : 64'($signed({meas_reg[15:0] - last_reg[15:0],
                                                               16'd0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            weight_reg    <= 17'd65536;
            alpha_reg     <= 17'd6553;
            out_lo_reg    <= 32'sh8000_0000;
            out_hi_reg    <= 32'sh7FFF_FFFF;
            lim_reg       <= 47'h7FFF_FFFF_0000;
            acc_reg       <= '0;
            last_reg      <= '0;
            primed_reg    <= 1'b0;
            df_reg        <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (pcfp_pkg::cfg_idx_t'(cfg_index))
                    pcfp_pkg::REG_GAIN_P:  gain_p_reg <= cfg_data[31:0];
                    pcfp_pkg::REG_GAIN_I:  gain_i_reg <= cfg_data[31:0];
                    pcfp_pkg::REG_GAIN_D:  gain_d_reg <= cfg_data[31:0];
                    pcfp_pkg::REG_WEIGHT:  weight_reg <= cfg_data[16:0];
                    pcfp_pkg::REG_ALPHA:   alpha_reg  <= cfg_data[16:0];
                    pcfp_pkg::REG_OUT_LO:  out_lo_reg <= cfg_data[31:0];
                    pcfp_pkg::REG_OUT_HI:  out_hi_reg <= cfg_data[31:0];
                    pcfp_pkg::REG_INT_LIM: lim_reg    <= cfg_data;
                    default:               lim_reg    <= lim_reg;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        if (operation)
                        begin
                            acc_reg    <= '0;
                            last_reg   <= '0;
                            primed_reg <= 1'b0;
                            df_reg     <= '0;
                        end
                        else if (time_step <= 0)
                        begin
                            drive_reg     <= '0;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            tgt_reg   <= target;
                            meas_reg  <= measured;
                            dt_reg    <= time_step;
                            state_reg <= S_WT;
                        end
                    end
                end
                S_WT:
                begin
                    wt_reg    <= fm;
                    state_reg <= S_PROP;
                end
                S_PROP:
                begin
                    prop_reg  <= fm;
                    state_reg <= S_INC;
                end
                S_INC:
                begin
                    acc_reg   <= pcfp_pkg::clamp_int(acc_reg + inc, lim_reg);
                    state_reg <= S_IL;
                end
                S_IL:
                begin
                    p1_reg    <= prod[47:0];
                    state_reg <= S_IH;
                end
                S_IH:
                begin
                    iterm_reg <= isum[47:16];
                    if (primed_reg)
                    begin
                        state_reg <= S_DSTART;
                    end
                    else
                    begin
                        deriv_reg <= '0;
                        state_reg <= S_SUM;
                    end
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (drsp.done)
                    begin
                        sample_reg <= drsp.quotient[31:0];
                        state_reg  <= S_F1;
                    end
                end
                S_F1:
                begin
                    t1_reg    <= fm;
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    df_reg    <= t1_reg + fm;
                    state_reg <= S_FD;
                end
                S_FD:
                begin
                    deriv_reg <= -fm;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    drive_reg <= drv;
                    back_reg  <= drv - prop_reg - deriv_reg;
                    if ((drv != total) && (gain_i_reg != 0))
                    begin
                        state_reg <= S_BSTART;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_BSTART:
                begin
                    state_reg <= S_BWAIT;
                end
                S_BWAIT:
                begin
                    if (drsp.done)
                    begin
                        acc_reg   <= pcfp_pkg::clamp_int(drsp.quotient, lim_reg);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    last_reg      <= meas_reg;
                    primed_reg    <= 1'b1;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> (state_reg == S_DWAIT) || (state_reg == S_BWAIT))
        else $error("divider busy outside a wait state");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("input taken while a result is pending");

    a_reset_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation) |=> !primed_reg && (acc_reg == 0))
        else $error("reset item left controller state");
`endif

endmodule
`default_nettype wire

[verif/pid_checker.sv]
`default_nettype none
module pid_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              operation,
    input  wire logic signed [31:0]                target,
    input  wire logic signed [31:0]                measured,
    input  wire logic signed [31:0]                time_step,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic signed [31:0]                drive,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [pcfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                     fail_count,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] k_p, k_i, k_d, lo_lim, hi_lim;
    logic [16:0]        w_sp, alpha;
    logic [46:0]        int_lim;

    logic signed [63:0] acc;
    logic signed [31:0] prev_meas;
    logic signed [31:0] filt;
    logic               primed;

    logic signed [31:0] drive_q[$];
    int                 errors = 0;

    assign fail_count = errors;
    assign pending    = drive_q.size();

    task automatic flag(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic signed [31:0] qmul(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = a * b;
        s = p >>> pcfp_pkg::FRAC;
        return s[31:0];
    endfunction

    function automatic logic signed [63:0] sat_acc(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = $signed({17'd0, int_lim});
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    task automatic apply_step(
        input logic               op,
        input logic signed [31:0] t,
        input logic signed [31:0] m,
        input logic signed [31:0] dt
    );
        logic signed [31:0] err, wt, wdiff, prop, iterm, deriv, total, drv, back;
        logic signed [31:0] diff, shifted, sample;
        logic signed [63:0] tmp, inc, num, keep, wide_ki;
        if (op)
        begin
            acc       = '0;
            prev_meas = '0;
            primed    = 1'b0;
            filt      = '0;
            return;
        end
        if (dt <= 0)
        begin
            drive_q.push_back('0);
            return;
        end
        err   = t - m;
        wt    = qmul($signed({47'd0, w_sp}), t);
        wdiff = wt - m;
        prop  = qmul(k_p, wdiff);
        tmp  = err * dt;
        inc  = tmp >>> pcfp_pkg::FRAC;
        acc  = sat_acc(acc + inc);
        tmp  = acc * k_i;
        tmp  = tmp >>> pcfp_pkg::FRAC;
        iterm = tmp[31:0];
        deriv = '0;
        if (primed)
        begin
            diff    = m - prev_meas;
            shifted = diff <<< pcfp_pkg::FRAC;
            sample  = shifted / dt;
            keep    = 64'sd65536 - $signed({47'd0, alpha});
            filt    = qmul(filt, $signed({47'd0, alpha})) + qmul(sample, keep);
            deriv   = -qmul(k_d, filt);
        end
        total = prop + iterm + deriv;
        if (total < lo_lim)
        begin
            drv = lo_lim;
        end
        else if (total > hi_lim)
        begin
            drv = hi_lim;
        end
        else
        begin
            drv = total;
        end
        if (drv != total && k_i != 0)
        begin
            back    = drv - prop - deriv;
            num     = back;
            num     = num <<< pcfp_pkg::FRAC;
            wide_ki = k_i;
            acc     = sat_acc(num / wide_ki);
        end
        prev_meas = m;
        primed    = 1'b1;
        drive_q.push_back(drv);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_p       = '0;
            k_i       = '0;
            k_d       = '0;
            w_sp      = 17'd65536;
            alpha     = 17'd6553;
            lo_lim    = 32'sh8000_0000;
            hi_lim    = 32'sh7FFF_FFFF;
            int_lim   = 47'h7FFF_FFFF_0000;
            acc       = '0;
            prev_meas = '0;
            primed    = 1'b0;
            filt      = '0;
            drive_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    flag($sformatf("unexpected transaction, drive %0d", drive));
                end
                else
                begin
                    if (drive !== drive_q[0])
                    begin
                        flag($sformatf("drive %0d, predicted %0d", drive, drive_q[0]));
                    end
                    void'(drive_q.pop_front());
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (pcfp_pkg::cfg_idx_t'(cfg_index))
                    pcfp_pkg::REG_GAIN_P:  k_p     = cfg_data[31:0];
                    pcfp_pkg::REG_GAIN_I:  k_i     = cfg_data[31:0];
                    pcfp_pkg::REG_GAIN_D:  k_d     = cfg_data[31:0];
                    pcfp_pkg::REG_WEIGHT:  w_sp    = cfg_data[16:0];
                    pcfp_pkg::REG_ALPHA:   alpha   = cfg_data[16:0];
                    pcfp_pkg::REG_OUT_LO:  lo_lim  = cfg_data[31:0];
                    pcfp_pkg::REG_OUT_HI:  hi_lim  = cfg_data[31:0];
                    pcfp_pkg::REG_INT_LIM: int_lim = cfg_data[46:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                apply_step(operation, target, measured, time_step);
            end
        end
    end

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE   = 32'sd65536;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                operation = 1'b0;
    logic signed [31:0]                  target = '0;
    logic signed [31:0]                  measured = '0;
    logic signed [31:0]                  time_step = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [31:0]                  drive;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [pcfp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [pcfp_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    int                                  fail_count;
    int                                  pending;
    int                                  send_idle = 0;
    int                                  stall_pct = 0;
    int                                  quiet = 0;

    pid_controller_fixed_point i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .target(target), .measured(measured),
        .time_step(time_step),
        .out_valid(out_valid), .out_stall(out_stall), .drive(drive),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pid_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .target(target), .measured(measured),
        .time_step(time_step),
        .out_valid(out_valid), .out_stall(out_stall), .drive(drive),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    task automatic send(
        input logic               op,
        input logic signed [31:0] t,
        input logic signed [31:0] m,
        input logic signed [31:0] dt
    );
        bit ok;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation <= op;
        target    <= t;
        measured  <= m;
        time_step <= dt;
        in_valid  <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end while (!ok);
    endtask

    task automatic write_reg(
        input pcfp_pkg::cfg_idx_t                idx,
        input logic [pcfp_pkg::CFG_DATA_W-1:0]   value
    );
        bit ok;
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end while (!ok);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic load_regs(
        input logic signed [31:0] kp,
        input logic signed [31:0] ki,
        input logic signed [31:0] kd,
        input logic [16:0]        w,
        input logic [16:0]        a,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi,
        input logic [46:0]        lim
    );
        write_reg(pcfp_pkg::REG_GAIN_P, {15'd0, kp});
        write_reg(pcfp_pkg::REG_GAIN_I, {15'd0, ki});
        write_reg(pcfp_pkg::REG_GAIN_D, {15'd0, kd});
        write_reg(pcfp_pkg::REG_WEIGHT, {30'd0, w});
        write_reg(pcfp_pkg::REG_ALPHA, {30'd0, a});
        write_reg(pcfp_pkg::REG_OUT_LO, {15'd0, lo});
        write_reg(pcfp_pkg::REG_OUT_HI, {15'd0, hi});
        write_reg(pcfp_pkg::REG_INT_LIM, lim);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(32'h1FFFFF)) - 32'sh100000;
            2: return $urandom_range(1) ? S_MAX : S_MIN;
            default: return $signed($urandom_range(32'h3FFFFFF)) - 32'sh2000000;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 4)
        begin
            return 0;
        end
        if (r < 8)
        begin
            return $urandom | 32'h8000_0000;
        end
        if (r < 14)
        begin
            return $urandom & 32'h7FFF_FFFF;
        end
        return $urandom_range(32'h40000, 1);
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        load_regs(ONE, ONE / 2, ONE / 4, 17'd65536, 17'd6553,
                  -(100 * ONE), 100 * ONE, 47'd65536000);
        send(1'b1, 0, 0, ONE);
        send(1'b0, ONE, 0, 0);
        send(1'b0, ONE, 0, S_MIN);
        send(1'b0, ONE, 0, ONE);
        send(1'b0, S_MAX, S_MIN, 1);
        send(1'b0, S_MIN, S_MAX, S_MAX);
        send(1'b0, 0, 0, 1);
        send(1'b0, 5 * ONE, 3 * ONE, ONE / 4);
        send(1'b0, -(5 * ONE), S_MAX, ONE);
        send(1'b1, S_MAX, S_MAX, S_MAX);
        send(1'b0, 2 * ONE, ONE, ONE);
        send(1'b0, 2 * ONE, -ONE, 1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: load_regs(S_MIN, S_MAX, S_MIN, 17'd0, 17'd65536,
                             S_MIN, S_MAX, 47'h7FFF_FFFF_FFFF);
                1: load_regs(ONE * 3, -ONE, ONE, 17'h1FFFF, 17'h1FFFF,
                             10 * ONE, -(10 * ONE), 47'd0);
                2: load_regs(ONE, 0, ONE / 2, 17'd32768, 17'd0,
                             -ONE, ONE, 47'd1000000);
                3: load_regs(S_MAX, S_MIN, S_MAX, 17'd65536, 17'd65536,
                             -(50 * ONE), 50 * ONE, 47'h7FFF_FFFF_0000);
                default: load_regs($urandom, $urandom, $urandom,
                                   17'($urandom), 17'($urandom),
                                   -$signed($urandom_range(32'h7FFFFFFF)),
                                   $urandom_range(32'h7FFFFFFF),
                                   47'({$urandom, $urandom}));
            endcase
            case (p % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 53; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 53; end
                default: begin send_idle = 17; stall_pct = 17; end
            endcase
            for (int n = 0; n < 105; n++)
            begin
                if ($urandom_range(99) < 3)
                begin
                    send(1'b1, $urandom, $urandom, $urandom);
                end
                else
                begin
                    send(1'b0, pick_value(), pick_value(), pick_step());
                end
            end
            drain();
            send_idle = 0;
            stall_pct = 0;
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
